FILE: rtl/irig_h_frame_encoder_assert.svh
// Assertion macros for the IRIG-H frame encoder.
// Expects clk and rst_n in the scope of each use.
`ifndef IRIG_H_FRAME_ENCODER_ASSERT_SVH
`define IRIG_H_FRAME_ENCODER_ASSERT_SVH

// Check that cond holds whenever trig holds in the same cycle
`define IRIGHFE_ASSERT_SAME(label, trig, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
    else $error("irighfe assertion failed");

// Check that cond holds in the cycle after trig
`define IRIGHFE_ASSERT_NEXT(label, trig, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
    else $error("irighfe assertion failed");

`endif

FILE: rtl/irighfe_pkg.sv
// Shared types, constants and functions of the IRIG-H frame encoder.
// Used by irighfe_code, irighfe_ticks and irig_h_frame_encoder; no dependencies.
package irighfe_pkg;

  localparam int unsigned FRAME_BITS = 60;
  localparam logic [5:0]  LAST_BIT   = 6'd59;

  // Position markers at bits 0, 9, 19, 29, 39, 49 and 59
  localparam logic [FRAME_BITS-1:0] MARK_MASK =
    (60'd1 << 0)  | (60'd1 << 9)  | (60'd1 << 19) | (60'd1 << 29) |
    (60'd1 << 39) | (60'd1 << 49) | (60'd1 << 59);

  // Configuration register indexes
  localparam logic [1:0] CFG_STRATUM = 2'd0;
  localparam logic [1:0] CFG_DISP    = 2'd1;
  localparam logic [1:0] CFG_PERIOD  = 2'd2;

  // Register reset values
  localparam logic [3:0]  STRATUM_RST = 4'd1;
  localparam logic [15:0] DISP_RST    = 16'd100;
  localparam logic [29:0] PERIOD_RST  = 30'd1000;

  // ceil(2^34 / 5): exact floor(x / 5) for any 32-bit x via (x * RECIP5) >> 34
  localparam logic [31:0] RECIP5      = 32'hCCCC_CCCD;
  localparam int unsigned RECIP5_SH   = 34;

  typedef enum logic [1:0] {
    SYM_ZERO = 2'd0,
    SYM_ONE  = 2'd1,
    SYM_MARK = 2'd2
  } sym_t;

  // Weights of the greedy BCD decomposition; every field uses a prefix
  localparam logic [8:0] WT [10] = '{
    9'd1, 9'd2, 9'd4, 9'd8, 9'd10, 9'd20, 9'd40, 9'd80, 9'd100, 9'd200
  };

  // Dispersion class band limits in microseconds
  localparam logic [15:0] DISP_LIM [7] = '{
    16'd250, 16'd500, 16'd1000, 16'd2000, 16'd4000, 16'd8000, 16'd16000
  };

  typedef struct packed {
    logic [5:0] seconds;
    logic [5:0] minutes;
    logic [4:0] hours;
    logic [8:0] day_of_year;
    logic [6:0] year_of_century;
  } time_t;

  typedef struct packed {
    logic [1:0] strat_code;
    logic [2:0] disp_class;
  } status_t;

  typedef struct packed {
    logic [29:0] t_zero;
    logic [29:0] t_one;
    logic [29:0] t_mark;
  } ticks_t;

  typedef struct packed {
    logic [9:0] mask;
    logic [8:0] rem;
  } greedy_t;

  // Greedy decomposition over weights hi down to lo, largest first
  function automatic greedy_t greedy_part(logic [8:0] value, int lo, int hi);
    greedy_t    g;
    logic [8:0] v;
    v      = value;
    g.mask = '0;
    for (int i = 9; i >= 0; i--) begin
      if (i >= lo && i <= hi && WT[i] <= v) begin
        g.mask[i] = 1'b1;
        v         = v - WT[i];
      end
    end
    g.rem = v;
    return g;
  endfunction

  // Map stratum 1, 2, 3 to codes 0, 1, 2 and anything else to 3
  function automatic logic [1:0] strat_code(logic [3:0] s);
    logic [1:0] c;
    case (s)
      4'd1:    c = 2'd0;
      4'd2:    c = 2'd1;
      4'd3:    c = 2'd2;
      default: c = 2'd3;
    endcase
    return c;
  endfunction

  // Band index of the dispersion: first limit it stays below, else 7
  function automatic logic [2:0] disp_class(logic [15:0] d);
    logic [2:0] c;
    c = 3'd7;
    for (int k = 6; k >= 0; k--) begin
      if (d < DISP_LIM[k]) begin
        c = 3'(k);
      end
    end
    return c;
  endfunction

endpackage

FILE: rtl/irighfe_code.sv
// Two-stage frame coder: greedy BCD decomposition of one time request, with the
// status codes, into the 60-bit mask of binary ones. Depends on irighfe_pkg.
module irighfe_code (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  irighfe_pkg::time_t                in_time,
  input  irighfe_pkg::status_t              status,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [irighfe_pkg::FRAME_BITS-1:0] out_ones
);

  // Stage 1: short fields decoded, day split into upper weights and remainder
  logic       s1_v_r, s1_v_nxt;
  logic [6:0] sec_c_r, min_c_r;
  logic [5:0] hr_c_r;
  logic [7:0] yr_c_r;
  logic [4:0] day_hi_r;
  logic [8:0] day_rem_r;

  // Stage 2: assembled ones mask
  logic                              s2_v_r, s2_v_nxt;
  logic [irighfe_pkg::FRAME_BITS-1:0] ones_r, ones_nxt;

  logic s1_en, s2_en;

  irighfe_pkg::greedy_t g_sec, g_min, g_hr, g_yr, g_day_hi, g_day_lo;

  // Advance each stage when it is empty or its content moves on
  assign s2_en    = !s2_v_r || !out_stall;
  assign s1_en    = !s1_v_r || s2_en;
  assign in_stall = !s1_en;

  assign s1_v_nxt = s1_en ? in_valid : s1_v_r;
  assign s2_v_nxt = s2_en ? s1_v_r : s2_v_r;

  // Stage 1 decomposition
  always_comb begin
    g_sec    = irighfe_pkg::greedy_part({3'd0, in_time.seconds}, 0, 6);
    g_min    = irighfe_pkg::greedy_part({3'd0, in_time.minutes}, 0, 6);
    g_hr     = irighfe_pkg::greedy_part({4'd0, in_time.hours}, 0, 5);
    g_yr     = irighfe_pkg::greedy_part({2'd0, in_time.year_of_century}, 0, 7);
    g_day_hi = irighfe_pkg::greedy_part(in_time.day_of_year, 5, 9);
  end

  // Stage 2: finish the day and place all fields
  always_comb begin
    g_day_lo = irighfe_pkg::greedy_part(day_rem_r, 0, 4);
    ones_nxt        = '0;
    ones_nxt[4:1]   = sec_c_r[3:0];
    ones_nxt[8:6]   = sec_c_r[6:4];
    ones_nxt[13:10] = min_c_r[3:0];
    ones_nxt[17:15] = min_c_r[6:4];
    ones_nxt[23:20] = hr_c_r[3:0];
    ones_nxt[26:25] = hr_c_r[5:4];
    ones_nxt[33:30] = g_day_lo.mask[3:0];
    ones_nxt[34+1]  = g_day_lo.mask[4];
    ones_nxt[38:36] = day_hi_r[2:0];
    ones_nxt[41:40] = day_hi_r[4:3];
    ones_nxt[44:43] = status.strat_code;
    ones_nxt[48:46] = status.disp_class;
    ones_nxt[53:50] = yr_c_r[3:0];
    ones_nxt[58:55] = yr_c_r[7:4];
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      s1_v_r <= s1_v_nxt;
      s2_v_r <= s2_v_nxt;
    end
  end

  // Payload, held while the stage stalls
  always_ff @(posedge clk) begin
    if (s1_en) begin
      sec_c_r   <= g_sec.mask[6:0];
      min_c_r   <= g_min.mask[6:0];
      hr_c_r    <= g_hr.mask[5:0];
      yr_c_r    <= g_yr.mask[7:0];
      day_hi_r  <= g_day_hi.mask[9:5];
      day_rem_r <= g_day_hi.rem;
    end
    if (s2_en) begin
      ones_r <= ones_nxt;
    end
  end

  assign out_valid = s2_v_r;
  assign out_ones  = ones_r;

endmodule

FILE: rtl/irighfe_ticks.sv
// Pulse high times for zero, one and marker from the bit period:
// floor of 2, 5 and 8 tenths, two register stages. Depends on irighfe_pkg.
module irighfe_ticks (
  input  logic                clk,
  input  logic [29:0]         bit_period,
  output irighfe_pkg::ticks_t ticks
);

  logic [61:0] prod_r;
  logic [29:0] per_r;
  logic [27:0] quot;
  logic [29:0] rem_full;
  logic [2:0]  rem;
  logic [1:0]  frac;
  irighfe_pkg::ticks_t ticks_r, ticks_nxt;

  // Take floor(P / 5) from the reciprocal product
  assign quot     = prod_r[irighfe_pkg::RECIP5_SH +: 28];
  assign rem_full = per_r - ({quot, 2'b00} + {2'b00, quot});
  assign rem      = rem_full[2:0];

  // floor(4r / 5) for r in 0..4
  always_comb begin
    case (rem)
      3'd2:    frac = 2'd1;
      3'd3:    frac = 2'd2;
      3'd4:    frac = 2'd3;
      default: frac = 2'd0;
    endcase
  end

  always_comb begin
    ticks_nxt.t_zero = {2'b00, quot};
    ticks_nxt.t_one  = {1'b0, per_r[29:1]};
    ticks_nxt.t_mark = {quot, 2'b00} + {28'd0, frac};
  end

  // Multiply, then correct and register
  always_ff @(posedge clk) begin
    prod_r  <= {32'd0, bit_period} * {30'd0, irighfe_pkg::RECIP5};
    per_r   <= bit_period;
    ticks_r <= ticks_nxt;
  end

  assign ticks = ticks_r;

endmodule

FILE: rtl/irig_h_frame_encoder.sv
// IRIG-H frame encoder top: config registers, frame serializer, output register.
// Path of a time request: coder stages 1 and 2, serializer, output register.
// Throughput: one symbol per cycle while out_stall is low; the next request
// is coded while the current frame is still being sent out.
// Reset (synchronous, rst_n low) clears valid bits and loads register defaults.
// Depends on irighfe_pkg, irighfe_code, irighfe_ticks and the assertion header.
`include "irig_h_frame_encoder_assert.svh"

module irig_h_frame_encoder (
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [29:0] cfg_wdata,
  // time request
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [5:0]  in_seconds,
  input  logic [5:0]  in_minutes,
  input  logic [4:0]  in_hours,
  input  logic [8:0]  in_day_of_year,
  input  logic [6:0]  in_year_of_century,
  // frame symbols
  output logic        out_valid,
  input  logic        out_stall,
  output logic [5:0]  out_bit_index,
  output logic [1:0]  out_symbol,
  output logic [29:0] out_high_ticks,
  output logic        out_last
);

  // Configuration registers
  logic [3:0]  stratum_r;
  logic [15:0] disp_r;
  logic [29:0] period_r;

  irighfe_pkg::time_t   in_time;
  irighfe_pkg::status_t status;
  irighfe_pkg::ticks_t  ticks;

  logic                              frm_valid, frm_stall;
  logic [irighfe_pkg::FRAME_BITS-1:0] frm_ones;

  // Serializer
  logic                              ser_v_r, ser_v_nxt;
  logic [irighfe_pkg::FRAME_BITS-1:0] mask_r;
  logic [5:0]                        cnt_r, cnt_nxt;
  logic                              out_load, ser_done, ser_free;
  irighfe_pkg::sym_t                 sym;
  logic [29:0]                       sym_ticks;

  // Output register
  logic              out_valid_r, out_valid_nxt;
  logic [5:0]        out_idx_r;
  irighfe_pkg::sym_t out_sym_r;
  logic [29:0]       out_ticks_r;
  logic              out_last_r;

  // Write configuration; unknown index is dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stratum_r <= irighfe_pkg::STRATUM_RST;
      disp_r    <= irighfe_pkg::DISP_RST;
      period_r  <= irighfe_pkg::PERIOD_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        irighfe_pkg::CFG_STRATUM: stratum_r <= cfg_wdata[3:0];
        irighfe_pkg::CFG_DISP:    disp_r    <= cfg_wdata[15:0];
        irighfe_pkg::CFG_PERIOD:  period_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    status.strat_code = irighfe_pkg::strat_code(stratum_r);
    status.disp_class = irighfe_pkg::disp_class(disp_r);
  end

  assign in_time = '{seconds: in_seconds, minutes: in_minutes, hours: in_hours,
                     day_of_year: in_day_of_year, year_of_century: in_year_of_century};

  irighfe_code u_code (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_time   (in_time),
    .status    (status),
    .out_valid (frm_valid),
    .out_stall (frm_stall),
    .out_ones  (frm_ones)
  );

  irighfe_ticks u_ticks (
    .clk        (clk),
    .bit_period (period_r),
    .ticks      (ticks)
  );

  // Handshake between serializer and output register
  assign out_load  = !out_valid_r || !out_stall;
  assign ser_done  = ser_v_r && out_load && (cnt_r == irighfe_pkg::LAST_BIT);
  assign ser_free  = !ser_v_r || ser_done;
  assign frm_stall = !ser_free;

  // Advance the bit counter or take the next frame
  always_comb begin
    ser_v_nxt = ser_v_r;
    cnt_nxt   = cnt_r;
    if (ser_free) begin
      ser_v_nxt = frm_valid;
      cnt_nxt   = '0;
    end else if (out_load) begin
      cnt_nxt = cnt_r + 6'd1;
    end
  end

  // Pick the symbol and its pulse width
  always_comb begin
    if (irighfe_pkg::MARK_MASK[cnt_r]) begin
      sym = irighfe_pkg::SYM_MARK;
    end else if (mask_r[cnt_r]) begin
      sym = irighfe_pkg::SYM_ONE;
    end else begin
      sym = irighfe_pkg::SYM_ZERO;
    end
    case (sym)
      irighfe_pkg::SYM_MARK: sym_ticks = ticks.t_mark;
      irighfe_pkg::SYM_ONE:  sym_ticks = ticks.t_one;
      default:               sym_ticks = ticks.t_zero;
    endcase
  end

  assign out_valid_nxt = out_load ? ser_v_r : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ser_v_r     <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      ser_v_r     <= ser_v_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Load frame and output payload
  always_ff @(posedge clk) begin
    if (ser_free && frm_valid) begin
      mask_r <= frm_ones;
    end
    if (out_load && ser_v_r) begin
      out_idx_r   <= cnt_r;
      out_sym_r   <= sym;
      out_ticks_r <= sym_ticks;
      out_last_r  <= (cnt_r == irighfe_pkg::LAST_BIT);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_bit_index  = out_idx_r;
  assign out_symbol     = out_sym_r;
  assign out_high_ticks = out_ticks_r;
  assign out_last       = out_last_r;

  // Last flag only on bit 59
  `IRIGHFE_ASSERT_SAME(a_last_idx, out_valid_r, out_last_r == (out_idx_r == irighfe_pkg::LAST_BIT))
  // Markers only at fixed positions
  `IRIGHFE_ASSERT_SAME(a_mark_pos, out_valid_r, (out_sym_r == irighfe_pkg::SYM_MARK) == irighfe_pkg::MARK_MASK[out_idx_r])
  // A frame in progress is never dropped before its last bit
  `IRIGHFE_ASSERT_NEXT(a_frame_hold, ser_v_r && (cnt_r != irighfe_pkg::LAST_BIT), ser_v_r)

endmodule

FILE: verif/irig_h_frame_encoder_checker.sv
// Scoreboard for the IRIG-H frame encoder: follows register writes, predicts
// the 60 symbols of every accepted time request and compares them in order.
// Depends on irighfe_pkg for register indexes and symbol codes.
module irig_h_frame_encoder_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [29:0] cfg_wdata,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [5:0]  in_seconds,
  input  logic [5:0]  in_minutes,
  input  logic [4:0]  in_hours,
  input  logic [8:0]  in_day_of_year,
  input  logic [6:0]  in_year_of_century,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [5:0]  out_bit_index,
  input  logic [1:0]  out_symbol,
  input  logic [29:0] out_high_ticks,
  input  logic        out_last,
  output int          fail_count,
  output int          pending_count
);

  // BCD weights, largest taken first; each field uses a prefix
  localparam int unsigned BCD_WT [10] = '{1, 2, 4, 8, 10, 20, 40, 80, 100, 200};

  typedef struct packed {
    logic [5:0]         bit_index;
    irighfe_pkg::sym_t  symbol;
    logic [29:0]        high_ticks;
    logic               last;
  } frame_sym_t;

  frame_sym_t  sym_q [$];
  logic [3:0]  stratum_r;
  logic [15:0] disp_r;
  logic [29:0] period_r;

  // Greedy decomposition over the first n weights; leftovers are dropped
  function automatic logic [9:0] weight_mask(input logic [8:0] value, input int n);
    logic [9:0]  mask;
    int unsigned rest;
    mask = '0;
    rest = value;
    for (int i = n - 1; i >= 0; i--) begin
      if (BCD_WT[i] <= rest) begin
        mask[i] = 1'b1;
        rest    = rest - BCD_WT[i];
      end
    end
    return mask;
  endfunction

  function automatic logic [1:0] stratum_to_code(input logic [3:0] s);
    case (s)
      4'd1:    return 2'd0;
      4'd2:    return 2'd1;
      4'd3:    return 2'd2;
      default: return 2'd3;
    endcase
  endfunction

  // Band 0 below 250 us, doubling up to 16000 us, band 7 above
  function automatic logic [2:0] disp_band(input logic [15:0] d);
    logic [2:0] band;
    band = 3'd7;
    for (int k = 6; k >= 0; k--) begin
      if (d < (16'd250 << k)) begin
        band = 3'(k);
      end
    end
    return band;
  endfunction

  // Build one frame from a time request and queue its symbols
  task automatic predict_frame(input logic [5:0] sec, input logic [5:0] mins,
                               input logic [4:0] hrs, input logic [8:0] day,
                               input logic [6:0] yr);
    logic [59:0] ones;
    logic [9:0]  m;
    logic [63:0] prod;
    frame_sym_t  e;
    ones = '0;
    m = weight_mask(sec, 7);
    ones[4:1]   = m[3:0];
    ones[8:6]   = m[6:4];
    m = weight_mask(mins, 7);
    ones[13:10] = m[3:0];
    ones[17:15] = m[6:4];
    m = weight_mask(hrs, 6);
    ones[23:20] = m[3:0];
    ones[26:25] = m[5:4];
    m = weight_mask(day, 10);
    ones[33:30] = m[3:0];
    ones[38:35] = m[7:4];
    ones[41:40] = m[9:8];
    m = weight_mask(yr, 8);
    ones[53:50] = m[3:0];
    ones[58:55] = m[7:4];
    ones[44:43] = stratum_to_code(stratum_r);
    ones[48:46] = disp_band(disp_r);
    for (int i = 0; i < 60; i++) begin
      e.bit_index = 6'(i);
      e.last      = (i == 59);
      if (i == 0 || i % 10 == 9) begin
        e.symbol = irighfe_pkg::SYM_MARK;
        prod     = 64'(period_r) * 64'd8 / 64'd10;
      end else if (ones[i]) begin
        e.symbol = irighfe_pkg::SYM_ONE;
        prod     = 64'(period_r) * 64'd5 / 64'd10;
      end else begin
        e.symbol = irighfe_pkg::SYM_ZERO;
        prod     = 64'(period_r) * 64'd2 / 64'd10;
      end
      e.high_ticks = prod[29:0];
      sym_q.push_back(e);
    end
  endtask

  task automatic compare_field(input string field, input logic [5:0] idx,
                               input logic [29:0] want, input logic [29:0] got);
    if (got !== want) begin
      $display("%0t: bit %0d %s expected %0d got %0d", $time, idx, field, want, got);
      fail_count++;
    end
  endtask

  // Track registers, predict on each time request, check each symbol
  always @(posedge clk) begin : watch
    frame_sym_t want;
    if (!rst_n) begin
      stratum_r  = irighfe_pkg::STRATUM_RST;
      disp_r     = irighfe_pkg::DISP_RST;
      period_r   = irighfe_pkg::PERIOD_RST;
      fail_count = 0;
      sym_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          irighfe_pkg::CFG_STRATUM: stratum_r = cfg_wdata[3:0];
          irighfe_pkg::CFG_DISP:    disp_r    = cfg_wdata[15:0];
          irighfe_pkg::CFG_PERIOD:  period_r  = cfg_wdata;
          default:                  ;
        endcase
      end
      if (in_valid && !in_stall) begin
        predict_frame(in_seconds, in_minutes, in_hours, in_day_of_year,
                      in_year_of_century);
      end
      if (out_valid && !out_stall) begin
        if (sym_q.size() == 0) begin
          $display("%0t: symbol at bit %0d with no frame pending", $time, out_bit_index);
          fail_count++;
        end else begin
          want = sym_q.pop_front();
          compare_field("bit_index", want.bit_index, 30'(want.bit_index),
                        30'(out_bit_index));
          compare_field("symbol", want.bit_index, 30'(want.symbol), 30'(out_symbol));
          compare_field("high_ticks", want.bit_index, want.high_ticks, out_high_ticks);
          compare_field("last", want.bit_index, 30'(want.last), 30'(out_last));
        end
      end
    end
    pending_count = sym_q.size();
  end

endmodule

FILE: verif/tb_irig_h_frame_encoder.sv
// Testbench top for the IRIG-H frame encoder: drives clock, reset, register
// writes and time requests with random gaps; the checker module judges output.
// Depends on irighfe_pkg, irig_h_frame_encoder and irig_h_frame_encoder_checker.
module tb_irig_h_frame_encoder;

  localparam logic [1:0] CFG_UNUSED   = 2'd3;
  localparam int         DRAIN_CYCLES = 10;
  localparam int         LIMIT_CYCLES = 400000;
  localparam int         SEGMENTS     = 9;
  localparam int         SEG_ITEMS    = 33;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [29:0] cfg_wdata;
  logic        in_valid;
  logic        in_stall;
  logic [5:0]  in_seconds;
  logic [5:0]  in_minutes;
  logic [4:0]  in_hours;
  logic [8:0]  in_day_of_year;
  logic [6:0]  in_year_of_century;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [5:0]  out_bit_index;
  logic [1:0]  out_symbol;
  logic [29:0] out_high_ticks;
  logic        out_last;
  int          fail_count;
  int          pending_count;
  int          send_idle_pct;
  int          recv_stall_pct;
  int          cycle_cnt;

  irig_h_frame_encoder u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_seconds         (in_seconds),
    .in_minutes         (in_minutes),
    .in_hours           (in_hours),
    .in_day_of_year     (in_day_of_year),
    .in_year_of_century (in_year_of_century),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_bit_index      (out_bit_index),
    .out_symbol         (out_symbol),
    .out_high_ticks     (out_high_ticks),
    .out_last           (out_last)
  );

  irig_h_frame_encoder_checker u_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_seconds         (in_seconds),
    .in_minutes         (in_minutes),
    .in_hours           (in_hours),
    .in_day_of_year     (in_day_of_year),
    .in_year_of_century (in_year_of_century),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_bit_index      (out_bit_index),
    .out_symbol         (out_symbol),
    .out_high_ticks     (out_high_ticks),
    .out_last           (out_last),
    .fail_count         (fail_count),
    .pending_count      (pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Stall the symbol channel at random, independent of valid
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // End the run as failed if it is still going when the cycle limit is reached
  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("tb_irig_h_frame_encoder failed");
    $finish;
  end

  // Offer one time request after random idle cycles, hold until accepted
  task automatic send_time(input logic [5:0] sec, input logic [5:0] mins,
                           input logic [4:0] hrs, input logic [8:0] day,
                           input logic [6:0] yr);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid           <= 1'b1;
    in_seconds         <= sec;
    in_minutes         <= mins;
    in_hours           <= hrs;
    in_day_of_year     <= day;
    in_year_of_century <= yr;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Drop valid and wait until every queued symbol is out
  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [29:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic settle_config(input logic [29:0] strat, input logic [29:0] disp,
                               input logic [29:0] period);
    wait_idle();
    write_reg(irighfe_pkg::CFG_STRATUM, strat);
    write_reg(irighfe_pkg::CFG_DISP, disp);
    write_reg(irighfe_pkg::CFG_PERIOD, period);
  endtask

  initial begin
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_index          = irighfe_pkg::CFG_STRATUM;
    cfg_wdata          = '0;
    in_valid           = 1'b0;
    in_seconds         = '0;
    in_minutes         = '0;
    in_hours           = '0;
    in_day_of_year     = '0;
    in_year_of_century = '0;
    send_idle_pct      = 14;
    recv_stall_pct     = 64;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Field extremes, leap second, out-of-range codes, reset registers
    send_time(6'd0, 6'd0, 5'd0, 9'd1, 7'd0);
    send_time(6'd59, 6'd59, 5'd23, 9'd366, 7'd99);
    send_time(6'd60, 6'd30, 5'd12, 9'd365, 7'd50);
    send_time(6'd63, 6'd63, 5'd31, 9'd511, 7'd127);
    send_time(6'd0, 6'd0, 5'd0, 9'd0, 7'd0);
    send_time(6'd56, 6'd34, 5'd12, 9'd123, 7'd45);
    send_time(6'd9, 6'd19, 5'd19, 9'd299, 7'd88);
    send_time(6'd1, 6'd40, 5'd20, 9'd200, 7'd80);
    send_time(6'd30, 6'd1, 5'd9, 9'd100, 7'd10);
    send_time(6'd61, 6'd60, 5'd24, 9'd400, 7'd100);

    // Register extremes: all stratum codes, band edges, tiny and huge periods
    settle_config(30'd0, 30'd0, 30'd0);
    send_time(6'd59, 6'd59, 5'd23, 9'd366, 7'd99);
    settle_config(30'd2, 30'd249, 30'd1);
    send_time(6'd45, 6'd15, 5'd7, 9'd77, 7'd33);
    settle_config(30'd3, 30'd250, 30'd9);
    send_time(6'd20, 6'd5, 5'd18, 9'd250, 7'd21);
    settle_config(30'd4, 30'd16000, 30'd10);
    send_time(6'd7, 6'd48, 5'd3, 9'd32, 7'd64);
    settle_config(30'h3FFF_FFFF, 30'd15999, 30'h3FFF_FFFF);
    send_time(6'd38, 6'd27, 5'd16, 9'd345, 7'd76);
    settle_config(30'h3FFF_FFF2, 30'h3FFF_FFFF, 30'd1000000000);
    send_time(6'd11, 6'd22, 5'd11, 9'd111, 7'd11);
    settle_config(30'd1, 30'd100, 30'd1000);
    write_reg(CFG_UNUSED, 30'h3FFF_FFFF);
    send_time(6'd59, 6'd58, 5'd22, 9'd364, 7'd98);

    // Random segments, each with its own register setting
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      if (seg == 3) begin
        send_idle_pct  = 64;
        recv_stall_pct = 14;
      end else if (seg == 6) begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
      wait_idle();
      write_reg(irighfe_pkg::CFG_STRATUM, 30'($urandom));
      if ($urandom_range(1)) begin
        write_reg(irighfe_pkg::CFG_DISP, 30'($urandom));
      end else begin
        write_reg(irighfe_pkg::CFG_DISP,
                  {14'($urandom), 16'((16'd250 << $urandom_range(6))
                                      - 16'($urandom_range(1)))});
      end
      case ($urandom_range(3))
        0:       write_reg(irighfe_pkg::CFG_PERIOD, 30'($urandom_range(20)));
        1:       write_reg(irighfe_pkg::CFG_PERIOD, 30'($urandom_range(100000, 10)));
        2:       write_reg(irighfe_pkg::CFG_PERIOD, 30'($urandom));
        default: write_reg(irighfe_pkg::CFG_PERIOD,
                           ($urandom_range(1)) ? 30'd1000000000 : 30'd10);
      endcase
      write_reg(CFG_UNUSED, 30'($urandom));
      for (int n = 0; n < SEG_ITEMS; n++) begin
        if ($urandom_range(99) < 85) begin
          send_time(6'($urandom_range(60)), 6'($urandom_range(59)),
                    5'($urandom_range(23)), 9'($urandom_range(366, 1)),
                    7'($urandom_range(99)));
        end else begin
          send_time(6'($urandom), 6'($urandom), 5'($urandom), 9'($urandom),
                    7'($urandom));
        end
      end
    end

    wait_idle();
    if (fail_count == 0 && pending_count == 0) begin
      $display("tb_irig_h_frame_encoder passed");
    end else begin
      $display("tb_irig_h_frame_encoder failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/irighfe_pkg.sv
rtl/irighfe_code.sv
rtl/irighfe_ticks.sv
rtl/irig_h_frame_encoder.sv
verif/irig_h_frame_encoder_checker.sv
verif/tb_irig_h_frame_encoder.sv
